// ----- hw/rtl/kcl_pkg.sv -----
// Shared types, codes and helper functions of the keypad code lock.
`default_nettype none
package kcl_pkg;

  localparam int CODE_DIGITS = 6;
  localparam int DIGIT_W     = 4;
  localparam int LEN_W       = $clog2(CODE_DIGITS + 1);

  typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] code_t;
  typedef logic [LEN_W-1:0]                    len_t;

  localparam logic [3:0] KEY_DIGITS  = 4'd10;
  localparam logic [3:0] KEY_CONFIRM = 4'd12;
  localparam logic [3:0] KEY_CLEAR   = 4'd13;
  localparam logic [3:0] KEY_ADMIN   = 4'd15;

  localparam logic [1:0] CFG_LOCKOUT_SECONDS  = 2'd0;
  localparam logic [1:0] CFG_MAX_ERRORS       = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd2;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_DIGIT      = 4'd1,
    EV_FULL       = 4'd2,
    EV_GRANTED    = 4'd3,
    EV_WRONG      = 4'd4,
    EV_LOCKOUT    = 4'd5,
    EV_ADMIN_OK   = 4'd6,
    EV_ADMIN_FAIL = 4'd7,
    EV_NEW_TAKEN  = 4'd8,
    EV_UPDATED    = 4'd9,
    EV_MISMATCH   = 4'd10,
    EV_CLEARED    = 4'd11,
    EV_ADMIN      = 4'd12,
    EV_COUNTDOWN  = 4'd13,
    EV_UNLOCKED   = 4'd14
  } event_e;

  typedef enum logic [1:0] {
    PH_USER    = 2'd0,
    PH_AUTH    = 2'd1,
    PH_NEW     = 2'd2,
    PH_CONFIRM = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    BEEP_SILENT  = 2'd0,
    BEEP_SUCCESS = 2'd1,
    BEEP_ERROR   = 2'd2
  } beep_e;

  typedef struct packed {
    logic [7:0]  lockout_seconds;
    logic [3:0]  max_errors;
    logic [15:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    beep_e      beep_kind;
    logic [7:0] seconds_left;
    logic       locked_flag;
    len_t       digits_entered;
    event_e     event_res;
  } res_t;

  function automatic code_t reset_code();
    code_t c;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      c[i] = DIGIT_W'((i + 1) % 10);
    end
    return c;
  endfunction

  // length must agree; only digits below the length are compared
  function automatic logic codes_eq(code_t a, len_t al, code_t b, len_t bl);
    logic eq;
    eq = (al == bl);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if ((al > LEN_W'(i)) && (a[i] != b[i])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/keypad_code_lock_top.sv -----
// Keypad code lock top level: stream ports, config registers, input and result registers.
// Path: an accepted beat waits in the input register until the result register is free,
// is then processed by the core, and its result beat is held in the result register until taken.
// Throughput: one beat per cycle; a stalled result holds processing, and an empty input
// register still takes one more beat meanwhile.
// Reset (rst_ni low, asynchronous): stored code 123456, entry empty, user phase,
// unlocked, config registers back to 5 s, 3 errors, 1000 ticks per second.
`default_nettype none
module keypad_code_lock_top
  import kcl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [3:0] key, [7:4] zero
  input  wire logic        s_axis_tuser,  // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] event_res, [6:4] digits_entered, [7] locked_flag, [15:8] seconds_left,
  // [17:16] beep_kind, [19:18] phase, [23:20] zero
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  logic       in_valid_q, in_valid_d;
  logic       in_action_q;
  logic [3:0] in_key_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  res_t       core_res;
  logic       s_fire, m_fire, proc;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOCKOUT_SECONDS:  cfg_d.lockout_seconds  = cfg_data_i[7:0];
        CFG_MAX_ERRORS:       cfg_d.max_errors       = cfg_data_i[3:0];
        CFG_TICKS_PER_SECOND: cfg_d.ticks_per_second = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_seconds  <= 8'd5;
      cfg_q.max_errors       <= 4'd3;
      cfg_q.ticks_per_second <= 16'd1000;
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_action_q <= s_axis_tuser;
      in_key_q    <= s_axis_tdata[3:0];
    end
    if (proc) begin
      out_res_q <= core_res;
    end
  end

  kcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_i   (proc),
    .action_i (in_action_q),
    .key_i    (in_key_q),
    .cfg_i    (cfg_q),
    .res_o    (core_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

endmodule
`default_nettype wire

// ----- hw/rtl/kcl_core.sv -----
// Lock state and combinational item processing of the keypad code lock.
`default_nettype none
module kcl_core
  import kcl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       proc_i,
  input  wire logic       action_i,
  input  wire logic [3:0] key_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  code_t       stored_q, stored_d;
  len_t        stored_len_q, stored_len_d;
  code_t       entry_q, entry_d;
  len_t        entry_len_q, entry_len_d;
  code_t       pend_q, pend_d;
  len_t        pend_len_q, pend_len_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  fail_q, fail_d;
  logic        lock_q, lock_d;
  logic [7:0]  remain_q, remain_d;
  logic [15:0] tick_q, tick_d;

  logic        match_stored, match_pend;
  logic [15:0] period;
  logic [16:0] tick_nxt;
  logic [7:0]  remain_dec;
  logic [3:0]  fail_inc;
  event_e      ev;
  beep_e       beep;

  assign match_stored = codes_eq(entry_q, entry_len_q, stored_q, stored_len_q);
  assign match_pend   = codes_eq(entry_q, entry_len_q, pend_q, pend_len_q);
  assign period       = (cfg_i.ticks_per_second == 16'd0) ? 16'd1 : cfg_i.ticks_per_second;
  assign tick_nxt     = {1'b0, tick_q} + 17'd1;
  assign remain_dec   = (remain_q == 8'd0) ? 8'd0 : remain_q - 8'd1;
  assign fail_inc     = (fail_q == FAIL_MAX) ? fail_q : fail_q + 4'd1;

  always_comb begin
    stored_d     = stored_q;
    stored_len_d = stored_len_q;
    entry_d      = entry_q;
    entry_len_d  = entry_len_q;
    pend_d       = pend_q;
    pend_len_d   = pend_len_q;
    phase_d      = phase_q;
    fail_d       = fail_q;
    lock_d       = lock_q;
    remain_d     = remain_q;
    tick_d       = tick_q;
    ev           = EV_NONE;
    beep         = BEEP_SILENT;
    if (proc_i) begin
      if (action_i) begin
        if (lock_q) begin
          if (tick_nxt >= {1'b0, period}) begin
            tick_d   = '0;
            remain_d = remain_dec;
            if (remain_dec == 8'd0) begin
              lock_d      = 1'b0;
              fail_d      = '0;
              entry_d     = '0;
              entry_len_d = '0;
              pend_d      = '0;
              pend_len_d  = '0;
              phase_d     = PH_USER;
              ev          = EV_UNLOCKED;
            end else begin
              ev = EV_COUNTDOWN;
            end
          end else begin
            tick_d = tick_nxt[15:0];
          end
        end
      end else if (!lock_q) begin
        if (key_i < KEY_DIGITS) begin
          if (entry_len_q < LEN_W'(CODE_DIGITS)) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (entry_len_q == LEN_W'(i)) begin
                entry_d[i] = key_i;
              end
            end
            entry_len_d = entry_len_q + LEN_W'(1);
            ev          = EV_DIGIT;
          end else begin
            ev = EV_FULL;
          end
        end else if (key_i == KEY_CONFIRM) begin
          // every branch leaves the entry empty
          entry_d     = '0;
          entry_len_d = '0;
          unique case (phase_q)
            PH_USER: begin
              if (match_stored) begin
                fail_d = '0;
                ev     = EV_GRANTED;
                beep   = BEEP_SUCCESS;
              end else begin
                fail_d = fail_inc;
                ev     = EV_WRONG;
                beep   = BEEP_ERROR;
                if (fail_inc >= cfg_i.max_errors) begin
                  lock_d   = 1'b1;
                  remain_d = (cfg_i.lockout_seconds == 8'd0) ? 8'd1 : cfg_i.lockout_seconds;
                  tick_d   = '0;
                  ev       = EV_LOCKOUT;
                end
              end
              pend_d     = '0;
              pend_len_d = '0;
              phase_d    = PH_USER;
            end
            PH_AUTH: begin
              if (match_stored) begin
                phase_d = PH_NEW;
                ev      = EV_ADMIN_OK;
              end else begin
                pend_d     = '0;
                pend_len_d = '0;
                phase_d    = PH_USER;
                ev         = EV_ADMIN_FAIL;
                beep       = BEEP_ERROR;
              end
            end
            PH_NEW: begin
              pend_d     = entry_q;
              pend_len_d = entry_len_q;
              phase_d    = PH_CONFIRM;
              ev         = EV_NEW_TAKEN;
            end
            PH_CONFIRM: begin
              if (match_pend) begin
                stored_d     = pend_q;
                stored_len_d = pend_len_q;
                ev           = EV_UPDATED;
                beep         = BEEP_SUCCESS;
              end else begin
                ev   = EV_MISMATCH;
                beep = BEEP_ERROR;
              end
              pend_d     = '0;
              pend_len_d = '0;
              phase_d    = PH_USER;
            end
            default: begin
              phase_d = PH_USER;
            end
          endcase
        end else if (key_i == KEY_CLEAR) begin
          entry_d     = '0;
          entry_len_d = '0;
          ev          = EV_CLEARED;
        end else if (key_i == KEY_ADMIN) begin
          if (phase_q == PH_USER) begin
            phase_d     = PH_AUTH;
            entry_d     = '0;
            entry_len_d = '0;
            ev          = EV_ADMIN;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.event_res      = ev;
    res_o.digits_entered = entry_len_d;
    res_o.locked_flag    = lock_d;
    res_o.seconds_left   = remain_d;
    res_o.beep_kind      = beep;
    res_o.phase          = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q     <= reset_code();
      stored_len_q <= LEN_W'(CODE_DIGITS);
      entry_q      <= '0;
      entry_len_q  <= '0;
      pend_q       <= '0;
      pend_len_q   <= '0;
      phase_q      <= PH_USER;
      fail_q       <= '0;
      lock_q       <= 1'b0;
      remain_q     <= '0;
      tick_q       <= '0;
    end else begin
      stored_q     <= stored_d;
      stored_len_q <= stored_len_d;
      entry_q      <= entry_d;
      entry_len_q  <= entry_len_d;
      pend_q       <= pend_d;
      pend_len_q   <= pend_len_d;
      phase_q      <= phase_d;
      fail_q       <= fail_d;
      lock_q       <= lock_d;
      remain_q     <= remain_d;
      tick_q       <= tick_d;
    end
  end

`ifndef SYNTHESIS
  a_entry_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_len_q <= LEN_W'(CODE_DIGITS))
    else $error("entry length beyond code size");

  a_lock_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q == (remain_q != 8'd0))
    else $error("lockout flag and remaining seconds disagree");

  a_lock_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> (phase_q == PH_USER) && (entry_len_q == '0))
    else $error("entry or admin phase active during lockout");

  a_unlock_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lock_q) |-> (fail_q == '0) && $past(action_i))
    else $error("unlock without tick or fail count left");
`endif

endmodule
`default_nettype wire
